// ===== rtl/rv32i_instruction_decoder_core_assert.svh =====
// Assertion macros shared by the decoder checker.
`ifndef RV32I_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define RV32I_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RVDEC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RVDEC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rvdec_pkg.sv =====
// Types and encoding constants for the RV32I instruction decoder.
package rvdec_pkg;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] instr_address;
   } req_type;

   typedef struct packed {
      logic               illegal;
      logic [5:0]         mnemonic_code;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_one;
      logic [4:0]         src_reg_two;
      logic signed [31:0] immediate;
      logic [31:0]        target_address;
   } rsp_type;

   // Major opcodes
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_OP     = 7'h33;

   // funct7 values
   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // funct3: branches
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   // funct3: load/store sizes
   localparam logic [2:0] F3_BYTE  = 3'd0;
   localparam logic [2:0] F3_HALF  = 3'd1;
   localparam logic [2:0] F3_WORD  = 3'd2;
   localparam logic [2:0] F3_BYTEU = 3'd4;
   localparam logic [2:0] F3_HALFU = 3'd5;

   // funct3: ALU operations
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SRL  = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // Mnemonic codes
   localparam logic [5:0] MN_LUI   = 6'd0;
   localparam logic [5:0] MN_AUIPC = 6'd1;
   localparam logic [5:0] MN_JAL   = 6'd2;
   localparam logic [5:0] MN_JALR  = 6'd3;
   localparam logic [5:0] MN_BEQ   = 6'd4;
   localparam logic [5:0] MN_BNE   = 6'd5;
   localparam logic [5:0] MN_BLT   = 6'd6;
   localparam logic [5:0] MN_BGE   = 6'd7;
   localparam logic [5:0] MN_BLTU  = 6'd8;
   localparam logic [5:0] MN_BGEU  = 6'd9;
   localparam logic [5:0] MN_LB    = 6'd10;
   localparam logic [5:0] MN_LH    = 6'd11;
   localparam logic [5:0] MN_LW    = 6'd12;
   localparam logic [5:0] MN_LBU   = 6'd13;
   localparam logic [5:0] MN_LHU   = 6'd14;
   localparam logic [5:0] MN_SB    = 6'd15;
   localparam logic [5:0] MN_SH    = 6'd16;
   localparam logic [5:0] MN_SW    = 6'd17;
   localparam logic [5:0] MN_ADDI  = 6'd18;
   localparam logic [5:0] MN_SLTI  = 6'd19;
   localparam logic [5:0] MN_SLTIU = 6'd20;
   localparam logic [5:0] MN_XORI  = 6'd21;
   localparam logic [5:0] MN_ORI   = 6'd22;
   localparam logic [5:0] MN_ANDI  = 6'd23;
   localparam logic [5:0] MN_SLLI  = 6'd24;
   localparam logic [5:0] MN_SRLI  = 6'd25;
   localparam logic [5:0] MN_SRAI  = 6'd26;
   localparam logic [5:0] MN_ADD   = 6'd27;
   localparam logic [5:0] MN_SUB   = 6'd28;
   localparam logic [5:0] MN_SLL   = 6'd29;
   localparam logic [5:0] MN_SLT   = 6'd30;
   localparam logic [5:0] MN_SLTU  = 6'd31;
   localparam logic [5:0] MN_XOR   = 6'd32;
   localparam logic [5:0] MN_SRL   = 6'd33;
   localparam logic [5:0] MN_SRA   = 6'd34;
   localparam logic [5:0] MN_OR    = 6'd35;
   localparam logic [5:0] MN_AND   = 6'd36;
   localparam logic [5:0] MN_NONE  = 6'd0;

endpackage

// ===== rtl/rv32i_instruction_decoder_core.sv =====
// RV32I instruction decoder: input register, decode logic, result register.
//
// Usage:
//   Drive req_payload (instruction word and its address) and pulse start.
//   A transaction is taken at every rising edge with start high and busy
//   low; busy stays low, so one instruction may be issued every cycle.
//   The decoded result appears on rsp_payload with rsp_strobe high for
//   exactly one cycle, once it has passed the input and result registers.
//   Results leave in issue order, one per instruction.
// Throughput: one instruction per cycle. The path holds the input register
//   and the result register; the opcode decode, immediate assembly and the
//   32-bit target adder sit between them.
// Illegal encodings give illegal = 1 with code, immediate and target zero;
//   register fields always carry the raw bits of the word.
// Reset: synchronous; clears both valid flags, dropping any transaction in
//   flight. The receiver cannot stall: each result is taken in the cycle
//   it is shown.
module rv32i_instruction_decoder_core
   import rvdec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_strobe,
   output rsp_type rsp_payload
);

   logic    req_valid_ff, req_valid_in;
   req_type req_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [31:0] word;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh;
   logic [5:0]  code;
   logic        ok;
   logic        has_target;
   logic [31:0] imm;

   assign busy         = 1'b0;
   assign req_valid_in = start && !busy;
   assign rsp_valid_in = req_valid_ff;

   assign word  = req_ff.instr_word;
   assign opc   = word[6:0];
   assign f3    = word[14:12];
   assign f7    = word[31:25];

   assign imm_i  = {{20{word[31]}}, word[31:20]};
   assign imm_s  = {{20{word[31]}}, word[31:25], word[11:7]};
   assign imm_b  = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
   assign imm_j  = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
   assign imm_u  = {12'h000, word[31:12]};
   assign imm_sh = {27'd0, word[24:20]};

   always_comb begin
      code       = MN_NONE;
      ok         = 1'b0;
      has_target = 1'b0;
      imm        = '0;
      unique case (opc)
         OPC_LUI: begin
            code = MN_LUI;
            ok   = 1'b1;
            imm  = imm_u;
         end
         OPC_AUIPC: begin
            code = MN_AUIPC;
            ok   = 1'b1;
            imm  = imm_u;
         end
         OPC_JAL: begin
            code       = MN_JAL;
            ok         = 1'b1;
            imm        = imm_j;
            has_target = 1'b1;
         end
         OPC_JALR: begin
            code = MN_JALR;
            ok   = (f3 == F3_ADD);
            imm  = imm_i;
         end
         OPC_BRANCH: begin
            imm        = imm_b;
            has_target = 1'b1;
            ok         = 1'b1;
            unique case (f3)
               F3_BEQ:  code = MN_BEQ;
               F3_BNE:  code = MN_BNE;
               F3_BLT:  code = MN_BLT;
               F3_BGE:  code = MN_BGE;
               F3_BLTU: code = MN_BLTU;
               F3_BGEU: code = MN_BGEU;
               default: ok = 1'b0;
            endcase
         end
         OPC_LOAD: begin
            imm = imm_i;
            ok  = 1'b1;
            unique case (f3)
               F3_BYTE:  code = MN_LB;
               F3_HALF:  code = MN_LH;
               F3_WORD:  code = MN_LW;
               F3_BYTEU: code = MN_LBU;
               F3_HALFU: code = MN_LHU;
               default:  ok = 1'b0;
            endcase
         end
         OPC_STORE: begin
            imm = imm_s;
            ok  = 1'b1;
            unique case (f3)
               F3_BYTE: code = MN_SB;
               F3_HALF: code = MN_SH;
               F3_WORD: code = MN_SW;
               default: ok = 1'b0;
            endcase
         end
         OPC_OPIMM: begin
            imm = imm_i;
            ok  = 1'b1;
            unique case (f3)
               F3_ADD:  code = MN_ADDI;
               F3_SLT:  code = MN_SLTI;
               F3_SLTU: code = MN_SLTIU;
               F3_XOR:  code = MN_XORI;
               F3_OR:   code = MN_ORI;
               F3_AND:  code = MN_ANDI;
               F3_SLL: begin
                  imm  = imm_sh;
                  code = MN_SLLI;
                  ok   = (f7 == F7_ZERO);
               end
               F3_SRL: begin
                  imm  = imm_sh;
                  code = (f7 == F7_ALT) ? MN_SRAI : MN_SRLI;
                  ok   = (f7 == F7_ZERO) || (f7 == F7_ALT);
               end
               default: ok = 1'b0;
            endcase
         end
         OPC_OP: begin
            ok = 1'b1;
            if (f7 == F7_ZERO) begin
               unique case (f3)
                  F3_ADD:  code = MN_ADD;
                  F3_SLL:  code = MN_SLL;
                  F3_SLT:  code = MN_SLT;
                  F3_SLTU: code = MN_SLTU;
                  F3_XOR:  code = MN_XOR;
                  F3_SRL:  code = MN_SRL;
                  F3_OR:   code = MN_OR;
                  F3_AND:  code = MN_AND;
                  default: ok = 1'b0;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               code = MN_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SRL) begin
               code = MN_SRA;
            end else begin
               ok = 1'b0;
            end
         end
         default: ok = 1'b0;
      endcase
   end

   always_comb begin
      rsp_in.illegal        = !ok;
      rsp_in.mnemonic_code  = ok ? code : MN_NONE;
      rsp_in.dest_reg       = word[11:7];
      rsp_in.src_reg_one    = word[19:15];
      rsp_in.src_reg_two    = word[24:20];
      rsp_in.immediate      = ok ? $signed(imm) : 32'sd0;
      rsp_in.target_address = (ok && has_target) ? req_ff.instr_address + imm : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load without reset; the valid flags qualify them.
   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_payload;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/rvdec_checker.sv =====
// Port-level assertions for the decoder, bound into the decoder core module.
`include "rv32i_instruction_decoder_core_assert.svh"

module rvdec_checker
   import rvdec_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_payload,
   input logic    rsp_strobe,
   input rsp_type rsp_payload
);

   logic issued;

   assign issued = start && !busy;

   // Every transaction yields a result on rsp_strobe.
   `RVDEC_ASSERT_NEXT(a_issue_gives_result, issued, ##1 rsp_strobe, "result missing after issue")

   // No result without a matching transaction.
   `RVDEC_ASSERT_IMPL(a_result_has_issue, rsp_strobe, $past(issued, 2), "result without issue")

   // The destination and second source register fields follow the issued word.
   `RVDEC_ASSERT_IMPL(a_fields_follow_word, rsp_strobe, (rsp_payload.dest_reg == $past(req_payload.instr_word[11:7], 2)) && (rsp_payload.src_reg_two == $past(req_payload.instr_word[24:20], 2)), "register fields do not match word")

   // Illegal results carry zero code, immediate and target; legal codes stay in range.
   `RVDEC_ASSERT_IMPL(a_illegal_zeroed, rsp_strobe && rsp_payload.illegal, (rsp_payload.mnemonic_code == MN_NONE) && (rsp_payload.immediate == 32'sd0) && (rsp_payload.target_address == 32'd0), "illegal result not cleared")

   `RVDEC_ASSERT_IMPL(a_code_in_range, rsp_strobe, rsp_payload.mnemonic_code <= MN_AND, "mnemonic code out of range")

endmodule

bind rv32i_instruction_decoder_core rvdec_checker u_rvdec_checker (.*);

// ===== tb/sv/rv32i_instruction_decoder_core_checker.sv =====
// Scoreboard for the instruction decoder: predicts each decode and compares results.
module rv32i_instruction_decoder_core_checker
   import rvdec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_payload,
   input  logic    rsp_strobe,
   input  rsp_type rsp_payload,
   output int      error_count,
   output int      outstanding
);

   typedef struct packed {
      req_type issued;
      rsp_type decoded;
   } pending_decode_type;

   pending_decode_type pending_decodes[$];
   int                 mismatch_total;

   function automatic rsp_type decode_instruction(input req_type req);
      logic [31:0] word;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] imm_i;
      logic [31:0] imm_s;
      logic [31:0] imm_b;
      logic [31:0] imm_j;
      logic [31:0] imm_u;
      logic [31:0] shamt;
      logic [31:0] imm;
      logic [5:0]  mnemonic;
      logic        known;
      logic        has_target;
      rsp_type     res;
      word  = req.instr_word;
      f3    = word[14:12];
      f7    = word[31:25];
      imm_i = {{20{word[31]}}, word[31:20]};
      imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
      imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
      imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
      imm_u = {12'b0, word[31:12]};
      shamt = {27'b0, word[24:20]};
      imm        = '0;
      mnemonic   = MN_NONE;
      known      = 1'b1;
      has_target = 1'b0;
      case (word[6:0])
         OPC_LUI: begin
            mnemonic = MN_LUI;
            imm      = imm_u;
         end
         OPC_AUIPC: begin
            mnemonic = MN_AUIPC;
            imm      = imm_u;
         end
         OPC_JAL: begin
            mnemonic   = MN_JAL;
            imm        = imm_j;
            has_target = 1'b1;
         end
         OPC_JALR: begin
            if (f3 == F3_ADD) begin
               mnemonic = MN_JALR;
               imm      = imm_i;
            end else begin
               known = 1'b0;
            end
         end
         OPC_BRANCH: begin
            imm        = imm_b;
            has_target = 1'b1;
            case (f3)
               F3_BEQ:  mnemonic = MN_BEQ;
               F3_BNE:  mnemonic = MN_BNE;
               F3_BLT:  mnemonic = MN_BLT;
               F3_BGE:  mnemonic = MN_BGE;
               F3_BLTU: mnemonic = MN_BLTU;
               F3_BGEU: mnemonic = MN_BGEU;
               default: known = 1'b0;
            endcase
         end
         OPC_LOAD: begin
            imm = imm_i;
            case (f3)
               F3_BYTE:  mnemonic = MN_LB;
               F3_HALF:  mnemonic = MN_LH;
               F3_WORD:  mnemonic = MN_LW;
               F3_BYTEU: mnemonic = MN_LBU;
               F3_HALFU: mnemonic = MN_LHU;
               default:  known = 1'b0;
            endcase
         end
         OPC_STORE: begin
            imm = imm_s;
            case (f3)
               F3_BYTE: mnemonic = MN_SB;
               F3_HALF: mnemonic = MN_SH;
               F3_WORD: mnemonic = MN_SW;
               default: known = 1'b0;
            endcase
         end
         OPC_OPIMM: begin
            imm = imm_i;
            case (f3)
               F3_ADD:  mnemonic = MN_ADDI;
               F3_SLT:  mnemonic = MN_SLTI;
               F3_SLTU: mnemonic = MN_SLTIU;
               F3_XOR:  mnemonic = MN_XORI;
               F3_OR:   mnemonic = MN_ORI;
               F3_AND:  mnemonic = MN_ANDI;
               F3_SLL: begin
                  imm = shamt;
                  if (f7 == F7_ZERO) mnemonic = MN_SLLI;
                  else known = 1'b0;
               end
               default: begin
                  // right shifts: funct7 picks logical or arithmetic
                  imm = shamt;
                  if (f7 == F7_ZERO) mnemonic = MN_SRLI;
                  else if (f7 == F7_ALT) mnemonic = MN_SRAI;
                  else known = 1'b0;
               end
            endcase
         end
         OPC_OP: begin
            if (f7 == F7_ZERO) begin
               case (f3)
                  F3_ADD:  mnemonic = MN_ADD;
                  F3_SLL:  mnemonic = MN_SLL;
                  F3_SLT:  mnemonic = MN_SLT;
                  F3_SLTU: mnemonic = MN_SLTU;
                  F3_XOR:  mnemonic = MN_XOR;
                  F3_SRL:  mnemonic = MN_SRL;
                  F3_OR:   mnemonic = MN_OR;
                  default: mnemonic = MN_AND;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_ADD) begin
               mnemonic = MN_SUB;
            end else if (f7 == F7_ALT && f3 == F3_SRL) begin
               mnemonic = MN_SRA;
            end else begin
               known = 1'b0;
            end
         end
         default: known = 1'b0;
      endcase
      res.illegal        = !known;
      res.mnemonic_code  = known ? mnemonic : MN_NONE;
      res.dest_reg       = word[11:7];
      res.src_reg_one    = word[19:15];
      res.src_reg_two    = word[24:20];
      res.immediate      = known ? imm : '0;
      res.target_address = (known && has_target) ? req.instr_address + imm : '0;
      return res;
   endfunction

   always @(posedge clock) begin
      pending_decode_type head;
      if (reset) begin
         pending_decodes.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_decodes.size() == 0) begin
               if (mismatch_total < 10)
                  $display("ERROR: result with no instruction outstanding: %h", rsp_payload);
               mismatch_total++;
            end else begin
               head = pending_decodes.pop_front();
               if (rsp_payload !== head.decoded) begin
                  if (mismatch_total < 10) begin
                     $display("ERROR: decode of %h at pc %h",
                              head.issued.instr_word, head.issued.instr_address);
                     $display("   expected ill=%b mn=%0d rd=%0d rs1=%0d rs2=%0d imm=%h tgt=%h",
                              head.decoded.illegal, head.decoded.mnemonic_code,
                              head.decoded.dest_reg, head.decoded.src_reg_one,
                              head.decoded.src_reg_two, head.decoded.immediate,
                              head.decoded.target_address);
                     $display("   actual   ill=%b mn=%0d rd=%0d rs1=%0d rs2=%0d imm=%h tgt=%h",
                              rsp_payload.illegal, rsp_payload.mnemonic_code,
                              rsp_payload.dest_reg, rsp_payload.src_reg_one,
                              rsp_payload.src_reg_two, rsp_payload.immediate,
                              rsp_payload.target_address);
                  end
                  mismatch_total++;
               end
            end
         end
         if (start && !busy) begin
            head.issued  = req_payload;
            head.decoded = decode_instruction(req_payload);
            pending_decodes.push_back(head);
         end
      end
      error_count <= mismatch_total;
      outstanding <= pending_decodes.size();
   end

endmodule

// ===== tb/sv/rv32i_instruction_decoder_core_test.sv =====
// Top-level test of the instruction decoder: clock, reset, stimulus and verdict.
module rv32i_instruction_decoder_core_test;
   import rvdec_pkg::*;

   localparam int         RANDOM_ITEMS = 1050;
   localparam int         QUIET_TAIL   = 150;
   localparam int         STALL_LIMIT  = 200;
   localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
   localparam logic [6:0] OPC_SYSTEM   = 7'h73;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;
   int      error_count;
   int      outstanding;
   int      stall_cycles;
   logic    allow_gaps;

   rv32i_instruction_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   rv32i_instruction_decoder_core_checker decode_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: end the run if neither channel moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Put opcode, funct3 and funct7 of one mnemonic into a word; other bits come from fill.
   function automatic logic [31:0] encode_op(input logic [5:0] mnemonic,
                                             input logic [31:0] fill);
      logic [31:0] word;
      word = fill;
      case (mnemonic)
         MN_LUI:   word[6:0] = OPC_LUI;
         MN_AUIPC: word[6:0] = OPC_AUIPC;
         MN_JAL:   word[6:0] = OPC_JAL;
         MN_JALR:  begin word[6:0] = OPC_JALR;   word[14:12] = F3_ADD;   end
         MN_BEQ:   begin word[6:0] = OPC_BRANCH; word[14:12] = F3_BEQ;   end
         MN_BNE:   begin word[6:0] = OPC_BRANCH; word[14:12] = F3_BNE;   end
         MN_BLT:   begin word[6:0] = OPC_BRANCH; word[14:12] = F3_BLT;   end
         MN_BGE:   begin word[6:0] = OPC_BRANCH; word[14:12] = F3_BGE;   end
         MN_BLTU:  begin word[6:0] = OPC_BRANCH; word[14:12] = F3_BLTU;  end
         MN_BGEU:  begin word[6:0] = OPC_BRANCH; word[14:12] = F3_BGEU;  end
         MN_LB:    begin word[6:0] = OPC_LOAD;   word[14:12] = F3_BYTE;  end
         MN_LH:    begin word[6:0] = OPC_LOAD;   word[14:12] = F3_HALF;  end
         MN_LW:    begin word[6:0] = OPC_LOAD;   word[14:12] = F3_WORD;  end
         MN_LBU:   begin word[6:0] = OPC_LOAD;   word[14:12] = F3_BYTEU; end
         MN_LHU:   begin word[6:0] = OPC_LOAD;   word[14:12] = F3_HALFU; end
         MN_SB:    begin word[6:0] = OPC_STORE;  word[14:12] = F3_BYTE;  end
         MN_SH:    begin word[6:0] = OPC_STORE;  word[14:12] = F3_HALF;  end
         MN_SW:    begin word[6:0] = OPC_STORE;  word[14:12] = F3_WORD;  end
         MN_ADDI:  begin word[6:0] = OPC_OPIMM;  word[14:12] = F3_ADD;   end
         MN_SLTI:  begin word[6:0] = OPC_OPIMM;  word[14:12] = F3_SLT;   end
         MN_SLTIU: begin word[6:0] = OPC_OPIMM;  word[14:12] = F3_SLTU;  end
         MN_XORI:  begin word[6:0] = OPC_OPIMM;  word[14:12] = F3_XOR;   end
         MN_ORI:   begin word[6:0] = OPC_OPIMM;  word[14:12] = F3_OR;    end
         MN_ANDI:  begin word[6:0] = OPC_OPIMM;  word[14:12] = F3_AND;   end
         MN_SLLI: begin
            word[6:0] = OPC_OPIMM; word[14:12] = F3_SLL; word[31:25] = F7_ZERO;
         end
         MN_SRLI: begin
            word[6:0] = OPC_OPIMM; word[14:12] = F3_SRL; word[31:25] = F7_ZERO;
         end
         MN_SRAI: begin
            word[6:0] = OPC_OPIMM; word[14:12] = F3_SRL; word[31:25] = F7_ALT;
         end
         MN_SUB: begin
            word[6:0] = OPC_OP; word[14:12] = F3_ADD; word[31:25] = F7_ALT;
         end
         MN_SRA: begin
            word[6:0] = OPC_OP; word[14:12] = F3_SRL; word[31:25] = F7_ALT;
         end
         MN_ADD:  begin word[6:0] = OPC_OP; word[14:12] = F3_ADD;  word[31:25] = F7_ZERO; end
         MN_SLL:  begin word[6:0] = OPC_OP; word[14:12] = F3_SLL;  word[31:25] = F7_ZERO; end
         MN_SLT:  begin word[6:0] = OPC_OP; word[14:12] = F3_SLT;  word[31:25] = F7_ZERO; end
         MN_SLTU: begin word[6:0] = OPC_OP; word[14:12] = F3_SLTU; word[31:25] = F7_ZERO; end
         MN_XOR:  begin word[6:0] = OPC_OP; word[14:12] = F3_XOR;  word[31:25] = F7_ZERO; end
         MN_SRL:  begin word[6:0] = OPC_OP; word[14:12] = F3_SRL;  word[31:25] = F7_ZERO; end
         MN_OR:   begin word[6:0] = OPC_OP; word[14:12] = F3_OR;   word[31:25] = F7_ZERO; end
         default: begin word[6:0] = OPC_OP; word[14:12] = F3_AND;  word[31:25] = F7_ZERO; end
      endcase
      return word;
   endfunction

   // Issue one transaction; called and returns at a falling edge.
   task automatic issue_instr(input logic [31:0] word, input logic [31:0] address);
      if (allow_gaps && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      start       <= 1'b1;
      req_payload <= '{instr_word: word, instr_address: address};
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] word;
      logic [31:0] address;
      logic [5:0]  mnemonic;
      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      allow_gaps  = 1'b1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // all-zero and all-one words are both illegal
      issue_instr(32'h0000_0000, 32'h0000_0000);
      issue_instr(32'hffff_ffff, 32'hffff_ffff);
      issue_instr({20'hfffff, 5'd31, OPC_LUI}, 32'h0000_0000);
      issue_instr({20'h00000, 5'd0, OPC_AUIPC}, 32'hffff_ffff);
      // jal extremes, with the target wrapping both ways
      issue_instr(encode_op(MN_JAL, 32'h8000_0000), 32'h0000_0000);
      issue_instr(encode_op(MN_JAL, 32'h7fff_ffff), 32'hffff_ffff);
      issue_instr(encode_op(MN_JAL, 32'hffff_ffff), 32'hffff_fffe);
      // jalr gets no target; nonzero funct3 is illegal
      issue_instr(encode_op(MN_JALR, 32'hffff_ffff), 32'h1234_5678);
      issue_instr({7'h00, 5'd1, 5'd2, F3_SLL, 5'd3, OPC_JALR}, 32'h0000_0100);
      issue_instr(encode_op(MN_BEQ, 32'hffff_ffff), 32'h0000_0000);
      issue_instr(encode_op(MN_BGEU, 32'h7fff_ff7f), 32'hffff_fff0);
      // funct3 2 is reserved for branches, 3 for loads, 3 and up for stores
      issue_instr({7'h7f, 5'd31, 5'd31, F3_SLT, 5'd31, OPC_BRANCH}, 32'h0000_0040);
      issue_instr({7'h00, 5'd4, 5'd5, F3_SLTU, 5'd6, OPC_LOAD}, 32'h0000_0040);
      issue_instr({7'h7f, 5'd31, 5'd31, F3_BYTEU, 5'd31, OPC_STORE}, 32'h0000_0040);
      issue_instr(encode_op(MN_SW, 32'hffff_ffff), 32'h0000_0000);
      issue_instr(encode_op(MN_SLLI, 32'hffff_ffff), 32'h0000_0000);
      issue_instr({F7_ALT, 5'd31, 5'd1, F3_SLL, 5'd2, OPC_OPIMM}, 32'h0000_0000);
      issue_instr(encode_op(MN_SRAI, 32'hffff_ffff), 32'h0000_0000);
      issue_instr({7'h01, 5'd7, 5'd8, F3_SRL, 5'd9, OPC_OPIMM}, 32'h0000_0000);
      issue_instr(encode_op(MN_SUB, 32'hffff_ffff), 32'hffff_ffff);
      issue_instr(encode_op(MN_SRA, 32'h0000_0000), 32'h0000_0000);
      issue_instr({F7_ALT, 5'd1, 5'd2, F3_SLL, 5'd3, OPC_OP}, 32'h0000_0000);
      issue_instr({7'h01, 5'd1, 5'd2, F3_ADD, 5'd3, OPC_OP}, 32'h0000_0000);
      issue_instr({25'h0ff_f000, OPC_MISC_MEM}, 32'h0000_0000);
      issue_instr({25'h000_0000, OPC_SYSTEM}, 32'h0000_0000);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n >= RANDOM_ITEMS - QUIET_TAIL) allow_gaps = 1'b0;
         mnemonic = 6'($urandom_range(MN_LUI, MN_AND));
         word     = encode_op(mnemonic, $urandom);
         case ($urandom_range(0, 19))
            0, 1: word = $urandom;
            2:    word[31:25] = 7'($urandom);
            3:    word[14:12] = 3'($urandom);
            default: ;
         endcase
         case ($urandom_range(0, 9))
            0:       address = 32'h0000_0000;
            1:       address = 32'hffff_ffff - $urandom_range(0, 4095);
            default: address = $urandom;
         endcase
         issue_instr(word, address);
      end
      start <= 1'b0;

      // drain outstanding decodes, then allow for the decoder's pipeline registers
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rvdec_pkg.sv
rtl/rv32i_instruction_decoder_core.sv
rtl/rvdec_checker.sv
tb/sv/rv32i_instruction_decoder_core_checker.sv
tb/sv/rv32i_instruction_decoder_core_test.sv
